// ===== src/rtss_pkg.sv =====
// Shared types and constants for the record table with sort and search.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rtss_pkg;

  localparam int KEY_W           = 32;
  localparam int PAY_W           = 64;
  localparam int IDX_W           = 7;
  localparam int HELD_W          = 8;
  localparam int MAX_RECORDS_DEF = 128;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_SORT   = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_LOAD,
    S_SORT_STEP,
    S_SORT_END,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_RD_WAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } rec_t;

  typedef struct packed {
    action_t                 action;
    logic signed [KEY_W-1:0] record_key;
    logic [PAY_W-1:0]        record_payload;
    logic [IDX_W-1:0]        entry_index;
  } cmd_t;

  typedef struct packed {
    status_t                 status;
    logic                    hit;
    logic signed [KEY_W-1:0] found_key;
    logic [PAY_W-1:0]        found_payload;
    logic [IDX_W-1:0]        found_index;
    logic [HELD_W-1:0]       entries_held;
  } res_t;

endpackage

`default_nettype wire

// ===== src/rtss_mem.sv =====
// Record store: one write port, one read port with registered read data.
// Depends on rtss_pkg for the record type.
`default_nettype none

module rtss_mem #(
  parameter int DEPTH = rtss_pkg::MAX_RECORDS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire rtss_pkg::rec_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output rtss_pkg::rec_t      rdata
);

  rtss_pkg::rec_t mem [DEPTH];
  rtss_pkg::rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/rtss_cmp.sv =====
// Shared key compare unit: signed less-than and equality on two keys.
// Depends on rtss_pkg for the key width.
`default_nettype none

module rtss_cmp (
  input  wire logic signed [rtss_pkg::KEY_W-1:0] a,
  input  wire logic signed [rtss_pkg::KEY_W-1:0] b,
  output logic                                   lt,
  output logic                                   eq
);

  assign lt = (a < b);
  assign eq = (a == b);

endmodule

`default_nettype wire

// ===== src/rtss_seq.sv =====
// Sequencer for the record table: clear, append, bubble sort, binary search, read.
// Drives the record store and the shared compare unit; depends on rtss_pkg.
`default_nettype none

module rtss_seq #(
  parameter int MAX_RECORDS = rtss_pkg::MAX_RECORDS_DEF,
  parameter int AW          = $clog2(MAX_RECORDS)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_ready,
  input  wire rtss_pkg::cmd_t                    cmd,
  output logic                                   mem_we,
  output logic [AW-1:0]                          mem_waddr,
  output rtss_pkg::rec_t                         mem_wdata,
  output logic [AW-1:0]                          mem_raddr,
  input  wire rtss_pkg::rec_t                    mem_rdata,
  output logic signed [rtss_pkg::KEY_W-1:0]      cmp_a,
  output logic signed [rtss_pkg::KEY_W-1:0]      cmp_b,
  input  wire logic                              cmp_lt,
  input  wire logic                              cmp_eq,
  output logic                                   res_valid,
  input  wire logic                              res_taken,
  output rtss_pkg::res_t                         res
);

  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int XW = (CW > rtss_pkg::IDX_W) ? CW : rtss_pkg::IDX_W;

  rtss_pkg::seq_state_t state_r, state_nxt;

  logic [CW-1:0]                     count_r, count_nxt;
  logic signed [rtss_pkg::KEY_W-1:0] key_r, key_nxt;
  rtss_pkg::status_t                 status_r, status_nxt;
  logic                              hit_r, hit_nxt;
  logic signed [rtss_pkg::KEY_W-1:0] fkey_r, fkey_nxt;
  logic [rtss_pkg::PAY_W-1:0]        fpay_r, fpay_nxt;
  logic [AW-1:0]                     fidx_r, fidx_nxt;
  logic [AW-1:0]                     j_r, j_nxt;
  logic [AW-1:0]                     last_r, last_nxt;
  rtss_pkg::rec_t                    cur_r, cur_nxt;
  logic [CW-1:0]                     lo_r, lo_nxt;
  logic [CW-1:0]                     end_r, end_nxt;
  logic [AW-1:0]                     mid_r, mid_nxt;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] j_p1;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] cnt_x;
  logic          idx_ok;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_w;
  logic [31:0]   fidx32;
  logic [31:0]   cnt32;

  assign cnt_m1  = count_r - CW'(1);
  assign j_p1    = j_r + AW'(1);
  assign idx_x   = XW'(cmd.entry_index);
  assign cnt_x   = XW'(count_r);
  assign idx_ok  = (idx_x < cnt_x);
  // mid = (lo + hi) / 2 with hi = end - 1; only used while lo < end
  assign mid_sum = {1'b0, lo_r} + {1'b0, end_r} - (CW + 1)'(1);
  assign mid_w   = mid_sum[CW:1];
  assign fidx32  = 32'(fidx_r);
  assign cnt32   = 32'(count_r);

  // hold off input words while reset is applied or an action runs
  assign cmd_ready = rst_n && (state_r == rtss_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtss_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.action)
            rtss_pkg::ACT_SORT: begin
              state_nxt = (count_r < CW'(2)) ? rtss_pkg::S_DONE : rtss_pkg::S_SORT_LOAD;
            end
            rtss_pkg::ACT_SEARCH: state_nxt = rtss_pkg::S_SRCH_CHK;
            rtss_pkg::ACT_READ: begin
              state_nxt = idx_ok ? rtss_pkg::S_RD_WAIT : rtss_pkg::S_DONE;
            end
            default: state_nxt = rtss_pkg::S_DONE;
          endcase
        end
      end
      rtss_pkg::S_SORT_LOAD: state_nxt = rtss_pkg::S_SORT_STEP;
      rtss_pkg::S_SORT_STEP: begin
        state_nxt = (j_p1 == last_r) ? rtss_pkg::S_SORT_END : rtss_pkg::S_SORT_STEP;
      end
      rtss_pkg::S_SORT_END: begin
        state_nxt = (last_r == AW'(1)) ? rtss_pkg::S_DONE : rtss_pkg::S_SORT_LOAD;
      end
      rtss_pkg::S_SRCH_CHK: begin
        state_nxt = (lo_r < end_r) ? rtss_pkg::S_SRCH_CMP : rtss_pkg::S_DONE;
      end
      rtss_pkg::S_SRCH_CMP: begin
        state_nxt = (!cmp_lt && cmp_eq) ? rtss_pkg::S_DONE : rtss_pkg::S_SRCH_CHK;
      end
      rtss_pkg::S_RD_WAIT: state_nxt = rtss_pkg::S_DONE;
      rtss_pkg::S_DONE: begin
        if (res_taken) begin
          state_nxt = rtss_pkg::S_IDLE;
        end
      end
      default: state_nxt = rtss_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    count_nxt  = count_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    fkey_nxt   = fkey_r;
    fpay_nxt   = fpay_r;
    fidx_nxt   = fidx_r;
    j_nxt      = j_r;
    last_nxt   = last_r;
    cur_nxt    = cur_r;
    lo_nxt     = lo_r;
    end_nxt    = end_r;
    mid_nxt    = mid_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = cur_r;
    mem_raddr  = '0;
    cmp_a      = mem_rdata.key;
    cmp_b      = key_r;
    res_valid  = 1'b0;
    case (state_r)
      rtss_pkg::S_IDLE: begin
        if (cmd_valid) begin
          status_nxt = rtss_pkg::ST_OK;
          hit_nxt    = 1'b0;
          fkey_nxt   = '0;
          fpay_nxt   = '0;
          fidx_nxt   = '0;
          key_nxt    = cmd.record_key;
          lo_nxt     = '0;
          end_nxt    = count_r;
          case (cmd.action)
            rtss_pkg::ACT_CLEAR: count_nxt = '0;
            rtss_pkg::ACT_APPEND: begin
              if (count_r == CW'(MAX_RECORDS)) begin
                status_nxt = rtss_pkg::ST_FULL;
              end else begin
                mem_we            = 1'b1;
                mem_waddr         = count_r[AW-1:0];
                mem_wdata.key     = cmd.record_key;
                mem_wdata.payload = cmd.record_payload;
                count_nxt         = count_r + CW'(1);
              end
            end
            rtss_pkg::ACT_SORT: begin
              mem_raddr = '0;
              last_nxt  = cnt_m1[AW-1:0];
            end
            rtss_pkg::ACT_READ: begin
              if (idx_ok) begin
                mem_raddr = idx_x[AW-1:0];
                fidx_nxt  = idx_x[AW-1:0];
              end else begin
                status_nxt = rtss_pkg::ST_BAD_INDEX;
              end
            end
            default: ;
          endcase
        end
      end
      rtss_pkg::S_SORT_LOAD: begin
        cur_nxt   = mem_rdata;
        mem_raddr = AW'(1);
        j_nxt     = '0;
      end
      rtss_pkg::S_SORT_STEP: begin
        // carry the larger record forward, drop the smaller one into slot j
        cmp_b     = cur_r.key;
        mem_we    = 1'b1;
        mem_waddr = j_r;
        if (cmp_lt) begin
          mem_wdata = mem_rdata;
        end else begin
          mem_wdata = cur_r;
          cur_nxt   = mem_rdata;
        end
        if (j_p1 != last_r) begin
          j_nxt     = j_p1;
          mem_raddr = j_r + AW'(2);
        end
      end
      rtss_pkg::S_SORT_END: begin
        mem_we    = 1'b1;
        mem_waddr = last_r;
        mem_wdata = cur_r;
        mem_raddr = '0;
        last_nxt  = last_r - AW'(1);
      end
      rtss_pkg::S_SRCH_CHK: begin
        if (lo_r < end_r) begin
          mem_raddr = mid_w[AW-1:0];
          mid_nxt   = mid_w[AW-1:0];
        end else begin
          status_nxt = rtss_pkg::ST_NOT_FOUND;
        end
      end
      rtss_pkg::S_SRCH_CMP: begin
        if (cmp_lt) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else if (cmp_eq) begin
          hit_nxt  = 1'b1;
          fkey_nxt = mem_rdata.key;
          fpay_nxt = mem_rdata.payload;
          fidx_nxt = mid_r;
        end else begin
          end_nxt = CW'(mid_r);
        end
      end
      rtss_pkg::S_RD_WAIT: begin
        hit_nxt  = 1'b1;
        fkey_nxt = mem_rdata.key;
        fpay_nxt = mem_rdata.payload;
      end
      rtss_pkg::S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtss_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
    fkey_r   <= fkey_nxt;
    fpay_r   <= fpay_nxt;
    fidx_r   <= fidx_nxt;
    j_r      <= j_nxt;
    last_r   <= last_nxt;
    cur_r    <= cur_nxt;
    lo_r     <= lo_nxt;
    end_r    <= end_nxt;
    mid_r    <= mid_nxt;
  end

  always_comb begin
    res.status        = status_r;
    res.hit           = hit_r;
    res.found_key     = fkey_r;
    res.found_payload = fpay_r;
    res.found_index   = fidx32[rtss_pkg::IDX_W-1:0];
    res.entries_held  = cnt32[rtss_pkg::HELD_W-1:0];
  end

endmodule

`default_nettype wire

// ===== src/record_table_sort_and_search.sv =====
// Top level of the record table: stream ports, result register and the sequencer.
// Depends on rtss_pkg, rtss_mem, rtss_cmp and rtss_seq.
//
//  channel | direction | tdata                               | tuser
//  in_     | slave     | key, payload, entry index           | action
//  out_    | master    | key, payload, index, entries held   | status, hit
//
// One word in, one word out. Clear, append and unused actions finish from idle, read
// waits for registered store data, search has a check and a compare per probe. Sort of
// n >= 2 records runs passes of a load, compare steps and an end write, one compare per
// cycle in the steps through the shared key compare unit and the store's single read
// port. Reset clears the record count, not the store. in_tready is low while an action
// runs; a finished result may sit in the output register while the next word is taken.
`default_nettype none

module record_table_sort_and_search #(
  parameter int MAX_RECORDS = rtss_pkg::MAX_RECORDS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,   // record_key[31:0], record_payload[95:32],
                                        // entry_index[102:96], zero pad
  input  wire logic [2:0]   in_tuser,   // action[2:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // found_key[31:0], found_payload[95:32],
                                        // found_index[102:96], entries_held[110:103], pad
  output logic [2:0]        out_tuser   // status[1:0], hit[2]
);

  localparam int AW = $clog2(MAX_RECORDS);

  rtss_pkg::cmd_t                    cmd;
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  rtss_pkg::rec_t                    mem_wdata;
  logic [AW-1:0]                     mem_raddr;
  rtss_pkg::rec_t                    mem_rdata;
  logic signed [rtss_pkg::KEY_W-1:0] cmp_a;
  logic signed [rtss_pkg::KEY_W-1:0] cmp_b;
  logic                              cmp_lt;
  logic                              cmp_eq;
  logic                              res_valid;
  logic                              res_taken;
  rtss_pkg::res_t                    res;

  logic           out_valid_r, out_valid_nxt;
  rtss_pkg::res_t out_res_r;

  assign cmd.action         = rtss_pkg::action_t'(in_tuser);
  assign cmd.record_key     = in_tdata[31:0];
  assign cmd.record_payload = in_tdata[95:32];
  assign cmd.entry_index    = in_tdata[102:96];

  rtss_mem #(
    .DEPTH (MAX_RECORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rtss_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  rtss_seq #(
    .MAX_RECORDS (MAX_RECORDS),
    .AW          (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp_lt    (cmp_lt),
    .cmp_eq    (cmp_eq),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res       (res)
  );

  // load a new result when the output register is empty or being drained
  assign res_taken = res_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_taken) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.hit, out_res_r.status};
  assign out_tdata  = {1'b0, out_res_r.entries_held, out_res_r.found_index,
                       out_res_r.found_payload, out_res_r.found_key};

endmodule

`default_nettype wire
